>>> rtl/core/can_bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit-timing solver package
// Field widths, range limits and the divider request/response types.
// ----------------------------------------------------------------------------
package can_bts_pkg;

	localparam int CLK_W  = 28;
	localparam int RATE_W = 23;
	localparam int SP_W   = 16;
	localparam int OP_W   = 28;
	localparam int PRES_W = 5;
	localparam int SEG1_W = 5;
	localparam int SEG2_W = 4;

	localparam int SP_BITS_DEF = 16;

	localparam int PRESC_MIN = 2;
	localparam int PRESC_MAX = 32;
	localparam int SEG1_MAX  = 32;
	localparam int SEG2_MAX  = 16;

	typedef struct packed {
		logic            start;
		logic [OP_W-1:0] dividend;
		logic [OP_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [OP_W-1:0] quotient;
		logic [OP_W-1:0] remainder;
	} div_rsp_t;

endpackage

>>> rtl/core/can_bit_timing_solver_top.sv
`timescale 1ns / 1ps
// Throughput: one item at a time; in_ready is high only while the sequencer is idle.
// Every division and modulo runs on one shared 28-step bit-serial divider.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset: arst_n asynchronous, clears sequencer and output valid, no clearing pass.
// ----------------------------------------------------------------------------
// CAN bit-timing solver
// Sequencer that derives prescaler and segment codes from clock and bit rate.
// ----------------------------------------------------------------------------
module can_bit_timing_solver_top #(
	parameter int SAMPLE_POINT_BITS = can_bts_pkg::SP_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [can_bts_pkg::CLK_W-1:0]    clock_freq,
	input  logic [can_bts_pkg::RATE_W-1:0]   bit_rate,
	input  logic [can_bts_pkg::SP_W-1:0]     sample_point,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             ok,
	output logic [can_bts_pkg::PRES_W-1:0]   prescaler_code,
	output logic [can_bts_pkg::SEG1_W-1:0]   seg1_code,
	output logic [can_bts_pkg::SEG2_W-1:0]   seg2_code
);
	import can_bts_pkg::*;

	localparam int PROD_W = OP_W + SP_W;
	localparam logic [SP_W-1:0] SP_MASK = (SAMPLE_POINT_BITS >= SP_W) ? {SP_W{1'b1}} :
		SP_W'((64'd1 << SAMPLE_POINT_BITS) - 64'd1);

	localparam logic [1:0] TRY_BASE = 2'd0;
	localparam logic [1:0] TRY_UP   = 2'd1;
	localparam logic [1:0] TRY_DOWN = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CDIV,
		S_CWAIT,
		S_MUL,
		S_BASE,
		S_TRY,
		S_GCD,
		S_GWAIT,
		S_PCHK,
		S_Q1WAIT,
		S_Q2WAIT,
		S_CHK,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [1:0]        try_q;
	logic [CLK_W-1:0]  clk_q;
	logic [RATE_W-1:0] rate_q;
	logic [SP_W-1:0]   sp_q;
	logic [OP_W-1:0]   clocks_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] prod_shift;
	logic [OP_W-1:0]   base_q;
	logic [OP_W-1:0]   seg1_q;
	logic [OP_W-1:0]   seg2_q;
	logic [OP_W-1:0]   ga_q;
	logic [OP_W-1:0]   gb_q;
	logic [OP_W-1:0]   q1p_q;
	logic [OP_W-1:0]   q2_q;
	logic              res_ok_q;
	logic [PRES_W-1:0] res_pc_q;
	logic [SEG1_W-1:0] res_c1_q;
	logic [SEG2_W-1:0] res_c2_q;
	logic              out_valid_q;

	logic [OP_W-1:0]   s1;
	logic              try_ok;
	logic              pchk_ok;
	logic              chk_ok;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	can_bts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign prod_shift = prod_q >> SAMPLE_POINT_BITS;

	always_comb begin
		unique case (try_q)
			TRY_BASE: s1 = base_q;
			TRY_UP:   s1 = base_q + OP_W'(1);
			default:  s1 = base_q - OP_W'(1);
		endcase
	end

	assign try_ok  = !(try_q == TRY_DOWN && base_q == '0) && (s1 < clocks_q);
	assign pchk_ok = (ga_q >= OP_W'(PRESC_MIN)) && (ga_q <= OP_W'(PRESC_MAX)) &&
		(seg1_q > ga_q);
	assign chk_ok  = (q1p_q >= OP_W'(2)) && (q1p_q <= OP_W'(SEG1_MAX + 1)) &&
		(q2_q >= OP_W'(1)) && (q2_q <= OP_W'(SEG2_MAX));

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = ga_q;
		div_req.divisor  = gb_q;
		unique case (state_q)
			S_CDIV: begin
				div_req.start    = (rate_q != '0);
				div_req.dividend = OP_W'(clk_q);
				div_req.divisor  = OP_W'(rate_q);
			end
			S_GCD: begin
				div_req.start = (gb_q != '0);
			end
			S_PCHK: begin
				div_req.start    = pchk_ok;
				div_req.dividend = seg1_q;
				div_req.divisor  = ga_q;
			end
			S_Q1WAIT: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = seg2_q;
				div_req.divisor  = ga_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			try_q          <= TRY_BASE;
			out_valid_q    <= 1'b0;
			ok             <= 1'b0;
			prescaler_code <= '0;
			seg1_code      <= '0;
			seg2_code      <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CDIV;
					end
				end
				S_CDIV: begin
					state_q <= (rate_q != '0) ? S_CWAIT : S_MUL;
				end
				S_CWAIT: begin
					if (div_rsp.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_BASE;
				end
				S_BASE: begin
					try_q   <= TRY_BASE;
					state_q <= S_TRY;
				end
				S_TRY: begin
					state_q <= try_ok ? S_GCD : S_CHK;
				end
				S_GCD: begin
					state_q <= (gb_q != '0) ? S_GWAIT : S_PCHK;
				end
				S_GWAIT: begin
					if (div_rsp.done) begin
						state_q <= S_GCD;
					end
				end
				S_PCHK: begin
					state_q <= pchk_ok ? S_Q1WAIT : S_CHK;
				end
				S_Q1WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_Q2WAIT;
					end
				end
				S_Q2WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (chk_ok || try_q == TRY_DOWN) begin
						state_q <= S_DONE;
					end else begin
						try_q   <= try_q + 2'd1;
						state_q <= S_TRY;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						ok             <= res_ok_q;
						prescaler_code <= res_pc_q;
						seg1_code      <= res_c1_q;
						seg2_code      <= res_c2_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				clk_q    <= clock_freq;
				rate_q   <= bit_rate;
				sp_q     <= sample_point & SP_MASK;
				res_ok_q <= 1'b0;
				res_pc_q <= '0;
				res_c1_q <= '0;
				res_c2_q <= '0;
			end
			S_CDIV: begin
				clocks_q <= '0;
			end
			S_CWAIT: begin
				if (div_rsp.done) begin
					clocks_q <= div_rsp.quotient;
				end
			end
			S_MUL: begin
				prod_q <= PROD_W'(clocks_q) * PROD_W'(sp_q);
			end
			S_BASE: begin
				base_q <= prod_shift[OP_W-1:0];
			end
			S_TRY: begin
				seg1_q <= s1;
				seg2_q <= clocks_q - s1;
				ga_q   <= s1;
				gb_q   <= clocks_q - s1;
				q1p_q  <= '0;
				q2_q   <= '0;
			end
			S_GWAIT: begin
				if (div_rsp.done) begin
					ga_q <= gb_q;
					gb_q <= div_rsp.remainder;
				end
			end
			S_PCHK: begin
				q1p_q <= '0;
				q2_q  <= '0;
			end
			S_Q1WAIT: begin
				if (div_rsp.done) begin
					q1p_q <= div_rsp.quotient;
				end
			end
			S_Q2WAIT: begin
				if (div_rsp.done) begin
					q2_q <= div_rsp.quotient;
				end
			end
			S_CHK: begin
				if (chk_ok) begin
					res_ok_q <= 1'b1;
					res_pc_q <= PRES_W'(ga_q - OP_W'(1));
					res_c1_q <= SEG1_W'(q1p_q - OP_W'(2));
					res_c2_q <= SEG2_W'(q2_q - OP_W'(1));
				end
			end
			default: begin
				res_ok_q <= res_ok_q;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/can_bts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit-timing solver divider
// Shared restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module can_bts_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  can_bts_pkg::div_req_t req,
	output can_bts_pkg::div_rsp_t rsp
);
	import can_bts_pkg::*;

	localparam int CNT_W = $clog2(OP_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OP_W-1:0]  rem_q;
	logic [OP_W-1:0]  quo_q;
	logic [OP_W-1:0]  dvs_q;
	logic [OP_W:0]    shifted;
	logic [OP_W:0]    diff;

	assign shifted = {rem_q, quo_q[OP_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OP_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[OP_W]) begin
				rem_q <= diff[OP_W-1:0];
				quo_q <= {quo_q[OP_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[OP_W-1:0];
				quo_q <= {quo_q[OP_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

>>> rtl/core/can_bts_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit-timing solver checker
// Port-level properties of the solver, bound to the top level.
// ----------------------------------------------------------------------------
module can_bts_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           ok,
	input logic [can_bts_pkg::PRES_W-1:0] prescaler_code,
	input logic [can_bts_pkg::SEG1_W-1:0] seg1_code,
	input logic [can_bts_pkg::SEG2_W-1:0] seg2_code
);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input still ready after a transfer");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result appeared one cycle after input transfer");

	a_fail_codes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |->
		(prescaler_code == '0 && seg1_code == '0 && seg2_code == '0))
		else $error("failed result carries nonzero codes");

	a_ok_prescaler: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ok) |-> (prescaler_code != '0))
		else $error("accepted result with prescaler below two");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(ok) && $stable(prescaler_code) &&
		$stable(seg1_code) && $stable(seg2_code)))
		else $error("stalled result changed");

endmodule

bind can_bit_timing_solver_top can_bts_chk u_can_bts_chk (.*);
